// File: hw/rtl/bmgv_pkg.sv
// ----------------------------------------------------------------------------
// bmgv_pkg
// Shared types, constants and helpers of the Box-Muller velocity generator.
// ----------------------------------------------------------------------------
package bmgv_pkg;

  localparam int unsigned UW = 32;  // uniform width, Q0.32
  localparam int unsigned SW = 32;  // sigma width, Q16.16
  localparam int unsigned EW = 16;  // clamp epsilon width
  localparam int unsigned OW = 40;  // velocity width, Q23.16
  localparam int unsigned TW = 36;  // signed trig value, Q.32

  localparam int unsigned LAT_RAD   = 63;
  localparam int unsigned LAT_TRIG  = 24;
  localparam int unsigned LAT_SCALE = 3;
  localparam int unsigned LAT_TOTAL = 1 + LAT_RAD + LAT_SCALE;

  localparam int unsigned FRAC_BITS  = 28;
  localparam int unsigned ROOT_STEPS = 32;
  localparam int unsigned TERMS      = 7;

  localparam logic [30:0]   TWO_LN2_Q30 = 31'd1488522236;
  localparam logic [31:0]   PI_Q30      = 32'd3373259426;
  localparam logic [OW-1:0] OUT_MAX     = 40'h7F_FFFF_FFFF;

  typedef logic signed [TW-1:0] trig_t;

  typedef struct packed {
    trig_t sn;
    trig_t cs;
  } sincos_t;

  // x in the low bits
  typedef struct packed {
    logic [OW-1:0] z;
    logic [OW-1:0] y;
    logic [OW-1:0] x;
  } vel_t;

  function automatic logic [UW-1:0] clamp_uniform(input logic [UW-1:0] u,
                                                  input logic [EW-1:0] eps);
    logic [UW:0]   gap;
    logic [UW-1:0] v;
    gap = 33'h1_0000_0000 - {1'b0, u};
    v   = u;
    if (gap < {17'b0, eps}) begin
      v = v - {16'b0, eps};
    end
    if (v <= {16'b0, eps}) begin
      v = v + {16'b0, eps};
    end
    if (v == '0) begin
      v = 32'd1;
    end
    return v;
  endfunction

endpackage

// File: hw/rtl/bmgv_radius.sv
// ----------------------------------------------------------------------------
// bmgv_radius
// Pipelined sqrt(-2 ln u): normalize, 28 squaring steps for log2, scale by
// 2 ln 2, then a 32-step restoring square root. Result in Q.29.
// ----------------------------------------------------------------------------
module bmgv_radius (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] u_i,
  output logic [31:0] r_o
);
  import bmgv_pkg::*;

  logic [31:0] u1_q;
  logic [4:0]  k1_d, k1_q;

  always_comb begin
    k1_d = '0;
    for (int i = 0; i < 32; i++) begin
      if (u_i[i]) begin
        k1_d = 5'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u1_q <= u_i;
      k1_q <= k1_d;
    end
  end

  // log2 stages: index 0 holds the normalized mantissa
  logic [31:0]          m_q    [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] frac_q [0:FRAC_BITS];
  logic [4:0]           k_q    [0:FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]    <= u1_q << (5'd31 - k1_q);
      frac_q[0] <= '0;
      k_q[0]    <= k1_q;
    end
  end

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] sh;
    logic [31:0] m_d;
    always_comb begin
      sq  = {32'b0, m_q[i]} * {32'b0, m_q[i]};
      sh  = sq[63:31];
      m_d = sh[32] ? sh[32:1] : sh[31:0];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[i+1]    <= m_d;
        frac_q[i+1] <= {frac_q[i][FRAC_BITS-2:0], sh[32]};
        k_q[i+1]    <= k_q[i];
      end
    end
  end

  // -2 ln u = (32 - log2 u) * 2 ln 2, Q.58
  logic [33:0] t;
  logic [64:0] wp;
  always_comb begin
    t  = 34'h2_0000_0000 - {1'b0, k_q[FRAC_BITS], frac_q[FRAC_BITS]};
    wp = t * TWO_LN2_Q30;
  end

  logic [63:0] n_q   [0:ROOT_STEPS];
  logic [63:0] res_q [0:ROOT_STEPS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]   <= wp[63:0];
      res_q[0] <= '0;
    end
  end

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * j);
    logic [63:0] trial;
    logic [63:0] n_d, res_d;
    always_comb begin
      trial = res_q[j] + Bit;
      if (n_q[j] >= trial) begin
        n_d   = n_q[j] - trial;
        res_d = (res_q[j] >> 1) + Bit;
      end else begin
        n_d   = n_q[j];
        res_d = res_q[j] >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[j+1]   <= n_d;
        res_q[j+1] <= res_d;
      end
    end
  end

  assign r_o = res_q[ROOT_STEPS][31:0];

endmodule

// File: hw/rtl/bmgv_sincos.sv
// ----------------------------------------------------------------------------
// bmgv_sincos
// Pipelined sine and cosine of a phase in turns: octant fold, Taylor series
// of seven terms each (three stages per term), quadrant rotation. Q.32.
// ----------------------------------------------------------------------------
module bmgv_sincos (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [31:0]       p_i,
  output bmgv_pkg::sincos_t sc_o
);
  import bmgv_pkg::*;

  typedef struct packed {
    logic [1:0]  quad;
    logic        swap;
    logic [31:0] x2;
    trig_t       s_acc;
    trig_t       c_acc;
    logic [32:0] s_term;
    logic [32:0] c_term;
    logic [31:0] s_n;
    logic [31:0] c_n;
  } lane_t;

  localparam int unsigned NST = 3 * TERMS;

  // fold and convert to radians
  logic [29:0] x;
  logic [61:0] xp;
  always_comb begin
    x  = p_i[29] ? 30'(31'h4000_0000 - {1'b0, p_i[29:0]}) : p_i[29:0];
    xp = x * PI_Q30;
  end

  logic [32:0] xr_q;
  logic [1:0]  quad1_q;
  logic        swap1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xr_q    <= xp[61:29];
      quad1_q <= p_i[31:30];
      swap1_q <= p_i[29];
    end
  end

  lane_t st_q [0:NST];

  logic [65:0] xsq;
  assign xsq = xr_q * xr_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].quad   <= quad1_q;
      st_q[0].swap   <= swap1_q;
      st_q[0].x2     <= xsq[63:32];
      st_q[0].s_acc  <= $signed({3'b0, xr_q});
      st_q[0].c_acc  <= $signed(36'h1_0000_0000);
      st_q[0].s_term <= xr_q;
      st_q[0].c_term <= 33'h1_0000_0000;
      st_q[0].s_n    <= '0;
      st_q[0].c_n    <= '0;
    end
  end

  for (genvar g = 0; g < TERMS; g++) begin : g_term
    localparam int unsigned Kk = g + 1;
    localparam int unsigned DivS = (2 * Kk) * (2 * Kk + 1);
    localparam int unsigned DivC = (2 * Kk - 1) * (2 * Kk);
    localparam logic [33:0] RcpS = 34'((64'd1 << 34) / DivS);
    localparam logic [33:0] RcpC = 34'((64'd1 << 34) / DivC);
    localparam logic [7:0]  DS8 = 8'(DivS);
    localparam logic [7:0]  DC8 = 8'(DivC);

    // term times x^2
    lane_t       a_d;
    logic [64:0] ps, pc;
    always_comb begin
      a_d     = st_q[3*g];
      ps      = st_q[3*g].s_term * st_q[3*g].x2;
      pc      = st_q[3*g].c_term * st_q[3*g].x2;
      a_d.s_n = ps[63:32];
      a_d.c_n = pc[63:32];
    end

    // reciprocal estimate, low by at most one
    lane_t       b_d;
    logic [65:0] qs, qc;
    always_comb begin
      b_d        = st_q[3*g+1];
      qs         = st_q[3*g+1].s_n * RcpS;
      qc         = st_q[3*g+1].c_n * RcpC;
      b_d.s_term = {1'b0, qs[65:34]};
      b_d.c_term = {1'b0, qc[65:34]};
    end

    // correct quotient and accumulate with alternating sign
    lane_t       c_d;
    logic [39:0] dms, dmc;
    logic [31:0] rms, rmc;
    logic [31:0] qfs, qfc;
    always_comb begin
      c_d = st_q[3*g+2];
      dms = st_q[3*g+2].s_term[31:0] * DS8;
      dmc = st_q[3*g+2].c_term[31:0] * DC8;
      rms = st_q[3*g+2].s_n - dms[31:0];
      rmc = st_q[3*g+2].c_n - dmc[31:0];
      qfs = st_q[3*g+2].s_term[31:0] + ((rms >= 32'(DivS)) ? 32'd1 : 32'd0);
      qfc = st_q[3*g+2].c_term[31:0] + ((rmc >= 32'(DivC)) ? 32'd1 : 32'd0);
      c_d.s_term = {1'b0, qfs};
      c_d.c_term = {1'b0, qfc};
      if (Kk % 2 == 1) begin
        c_d.s_acc = st_q[3*g+2].s_acc - $signed({4'b0, qfs});
        c_d.c_acc = st_q[3*g+2].c_acc - $signed({4'b0, qfc});
      end else begin
        c_d.s_acc = st_q[3*g+2].s_acc + $signed({4'b0, qfs});
        c_d.c_acc = st_q[3*g+2].c_acc + $signed({4'b0, qfc});
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[3*g+1] <= a_d;
        st_q[3*g+2] <= b_d;
        st_q[3*g+3] <= c_d;
      end
    end
  end

  trig_t   s, c;
  sincos_t sc_d, sc_q;
  always_comb begin
    s = st_q[NST].swap ? st_q[NST].c_acc : st_q[NST].s_acc;
    c = st_q[NST].swap ? st_q[NST].s_acc : st_q[NST].c_acc;
    case (st_q[NST].quad)
      2'd0:    begin sc_d.cs = c;  sc_d.sn = s;  end
      2'd1:    begin sc_d.cs = -s; sc_d.sn = c;  end
      2'd2:    begin sc_d.cs = -c; sc_d.sn = -s; end
      default: begin sc_d.cs = s;  sc_d.sn = -c; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc_q <= sc_d;
    end
  end

  assign sc_o = sc_q;

endmodule

// File: hw/rtl/bmgv_scale.sv
// ----------------------------------------------------------------------------
// bmgv_scale
// Radius times sigma times trig value, truncated to Q23.16, signed and
// saturated. Three stages.
// ----------------------------------------------------------------------------
module bmgv_scale (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [31:0]     r_i,
  input  logic [31:0]     sigma_i,
  input  bmgv_pkg::trig_t trig_i,
  output logic [39:0]     v_o
);
  import bmgv_pkg::*;

  logic [63:0] a_q;
  logic [34:0] mag_q;
  logic        neg1_q;
  trig_t       ta;

  assign ta = trig_i[TW-1] ? -trig_i : trig_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= {32'b0, r_i} * {32'b0, sigma_i};
      mag_q  <= ta[34:0];
      neg1_q <= trig_i[TW-1];
    end
  end

  logic [66:0] hp, lp;
  logic [63:0] ph_q;
  logic [34:0] pl_q;
  logic        neg2_q;

  always_comb begin
    hp = a_q[63:32] * mag_q;
    lp = a_q[31:0] * mag_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q   <= hp[63:0];
      pl_q   <= lp[66:32];
      neg2_q <= neg1_q;
    end
  end

  logic [63:0]   p;
  logic [OW-1:0] mag, v_d, v_q;
  always_comb begin
    p   = ph_q + {29'b0, pl_q};
    mag = {5'b0, p[63:29]};
    if (mag > OUT_MAX) begin
      mag = OUT_MAX;
    end
    v_d = neg2_q ? -mag : mag;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= v_d;
    end
  end

  assign v_o = v_q;

endmodule

// File: hw/rtl/box_muller_gaussian_velocity.sv
// ----------------------------------------------------------------------------
// box_muller_gaussian_velocity
// Gaussian velocity generator: four uniforms and three sigmas in, three
// normally distributed velocity components out.
// ----------------------------------------------------------------------------
// Input words carry four Q0.32 uniforms and three Q16.16 sigmas; output
// words carry vel_x, vel_y, vel_z in signed Q23.16. One output word per
// input word, in order.
// Throughput: one word per cycle while the output queue is not full. The
// radius path sets the pipeline depth: the log2 squaring chain (28 stages)
// and the square root (32 stages); trig values and sigmas ride delay lines
// alongside. The clamp epsilon is written over the cfg channel (always
// ready); the user must write it only while no word is in flight, which
// the block does not enforce. Reset sets it to 43 and empties the pipeline.
// Results land in a two-word output queue. While the receiver stalls the
// queue fills; once full, the whole pipeline holds and s_axis_tready drops,
// so nothing is lost or repeated. s_axis_tready comes from a register and
// has no combinational path from m_axis_tready.
// ----------------------------------------------------------------------------
module box_muller_gaussian_velocity (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // uniform_a1, uniform_a2, uniform_b1, uniform_b2, sigma_x, sigma_y, sigma_z
  input  logic [223:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // vel_x, vel_y, vel_z
  output logic [119:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i
);
  import bmgv_pkg::*;

  localparam int unsigned TDLY = LAT_RAD - LAT_TRIG;

  logic [EW-1:0] eps_q;
  logic [1:0]    cnt_q;
  logic          en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= 16'd43;
    end else if (cfg_valid_i) begin
      eps_q <= cfg_data_i;
    end
  end

  assign en            = (cnt_q != 2'd2);
  assign s_axis_tready = en;

  // clamp stage
  logic [31:0] a1_q, a2_q, b1_q, b2_q;
  logic [95:0] sig_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q  <= clamp_uniform(s_axis_tdata[31:0], eps_q);
      a2_q  <= clamp_uniform(s_axis_tdata[63:32], eps_q);
      b1_q  <= clamp_uniform(s_axis_tdata[95:64], eps_q);
      b2_q  <= clamp_uniform(s_axis_tdata[127:96], eps_q);
      sig_q <= s_axis_tdata[223:128];
    end
  end

  logic [LAT_TOTAL-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT_TOTAL-2:0], s_axis_tvalid};
    end
  end

  logic [31:0] ra, rb;
  sincos_t     sca, scb;

  bmgv_radius u_rad_a (.clk_i, .en_i(en), .u_i(a1_q), .r_o(ra));
  bmgv_radius u_rad_b (.clk_i, .en_i(en), .u_i(b1_q), .r_o(rb));
  bmgv_sincos u_sc_a  (.clk_i, .en_i(en), .p_i(a2_q), .sc_o(sca));
  bmgv_sincos u_sc_b  (.clk_i, .en_i(en), .p_i(b2_q), .sc_o(scb));

  // align trig values and sigmas with the radius
  logic [3*TW-1:0] td_q [0:TDLY-1];
  logic [95:0]     sd_q [0:LAT_RAD-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      td_q[0] <= {scb.cs, sca.sn, sca.cs};
      sd_q[0] <= sig_q;
      for (int i = 1; i < TDLY; i++) begin
        td_q[i] <= td_q[i-1];
      end
      for (int i = 1; i < LAT_RAD; i++) begin
        sd_q[i] <= sd_q[i-1];
      end
    end
  end

  vel_t vel;

  bmgv_scale u_scl_x (
    .clk_i, .en_i(en), .r_i(ra), .sigma_i(sd_q[LAT_RAD-1][31:0]),
    .trig_i(td_q[TDLY-1][TW-1:0]), .v_o(vel.x)
  );
  bmgv_scale u_scl_y (
    .clk_i, .en_i(en), .r_i(ra), .sigma_i(sd_q[LAT_RAD-1][63:32]),
    .trig_i(td_q[TDLY-1][2*TW-1:TW]), .v_o(vel.y)
  );
  bmgv_scale u_scl_z (
    .clk_i, .en_i(en), .r_i(rb), .sigma_i(sd_q[LAT_RAD-1][95:64]),
    .trig_i(td_q[TDLY-1][3*TW-1:2*TW]), .v_o(vel.z)
  );

  // two-word output queue
  vel_t fifo_q [0:1];
  logic wr_q, rd_q;
  logic push, pop;

  assign push = en && vld_q[LAT_TOTAL-1];
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= vel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = fifo_q[rd_q];

endmodule

// File: hw/rtl/bmgv_checker.sv
// ----------------------------------------------------------------------------
// bmgv_checker
// Port-level checks of the velocity generator, bound to the top level.
// ----------------------------------------------------------------------------
module bmgv_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [119:0] m_axis_tdata
);

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // input backpressure only when results are waiting
  a_bp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending output");

  // a draining receiver never blocks the input the next cycle
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |=> s_axis_tready)
    else $error("input stalled after drain");

endmodule

bind box_muller_gaussian_velocity bmgv_checker u_bmgv_checker (
  .clk_i,
  .rst_ni,
  .s_axis_tready,
  .m_axis_tvalid,
  .m_axis_tready,
  .m_axis_tdata
);

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Box-Muller velocity generator. A built-in
// fixed-point predictor computes the expected vel_x/vel_y/vel_z for every
// accepted word. Random idling runs on both stream sides, and the clamp
// epsilon is swept over several values, the extremes among them.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bmgv_pkg::*;

  localparam longint unsigned ONE_Q32 = 64'h1_0000_0000;

  class velocity_scoreboard;
    vel_t            velocity_q[$];
    logic [EW-1:0]   epsilon;
    int              errors;
    int              matched;

    function new();
      epsilon = 16'd43;
      errors  = 0;
      matched = 0;
    endfunction

    function automatic longint unsigned clamp_u(longint unsigned u);
      longint unsigned e;
      e = epsilon;
      if (ONE_Q32 - u < e) u = u - e;
      if (u <= e) u = u + e;
      if (u == 0) u = 1;
      return u;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n   = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // sqrt(-2 ln(u/2^32)), Q.29
    function automatic longint unsigned radius_of(longint unsigned u);
      int              k;
      longint unsigned m, frac, t;
      k    = 31;
      frac = 0;
      while (k > 0 && u[k] == 1'b0) k--;
      m = u << (31 - k);
      for (int i = 0; i < FRAC_BITS; i++) begin
        m    = (m * m) >> 31;
        frac = frac << 1;
        if (m >= ONE_Q32) begin
          frac = frac | 1;
          m    = m >> 1;
        end
      end
      t = (64'd32 << 28) - ((longint'(k) << 28) + frac);
      return int_sqrt(t * longint'(TWO_LN2_Q30));
    endfunction

    function automatic void phase_trig(longint unsigned p, output longint cs,
                                       output longint sn);
      longint unsigned quad, g, x, xr, x2, term;
      longint          s, c, tmp;
      bit              swap;
      quad = (p >> 30) & 3;
      g    = p & 64'h3FFF_FFFF;
      swap = g >= (64'd1 << 29);
      x    = swap ? (64'd1 << 30) - g : g;
      xr   = (x * longint'(PI_Q30)) >> 29;
      x2   = (xr * xr) >> 32;
      term = xr;
      s    = xr;
      for (longint unsigned k = 1; k <= TERMS; k++) begin
        term = ((term * x2) >> 32) / ((2 * k) * (2 * k + 1));
        s    = k[0] ? s - longint'(term) : s + longint'(term);
      end
      term = ONE_Q32;
      c    = ONE_Q32;
      for (longint unsigned k = 1; k <= TERMS; k++) begin
        term = ((term * x2) >> 32) / ((2 * k - 1) * (2 * k));
        c    = k[0] ? c - longint'(term) : c + longint'(term);
      end
      if (swap) begin
        tmp = s; s = c; c = tmp;
      end
      case (quad)
        0: begin cs = c;  sn = s;  end
        1: begin cs = -s; sn = c;  end
        2: begin cs = -c; sn = -s; end
        default: begin cs = s; sn = -c; end
      endcase
    endfunction

    function automatic logic [OW-1:0] scaled(longint unsigned r,
                                             longint unsigned sigma, longint trig);
      longint unsigned a, mt, p, mag;
      longint          v;
      a   = r * sigma;
      mt  = (trig < 0) ? longint'(-trig) : longint'(trig);
      p   = (a >> 32) * mt + (((a & 64'hFFFF_FFFF) * mt) >> 32);
      mag = p >> 29;
      if (mag > longint'(OUT_MAX)) mag = OUT_MAX;
      v = (trig < 0) ? -longint'(mag) : longint'(mag);
      return v[OW-1:0];
    endfunction

    function void note_word(logic [223:0] d);
      longint unsigned ra, rb;
      longint          ca, sa, cb, sb;
      vel_t            v;
      ra = radius_of(clamp_u(d[31:0]));
      rb = radius_of(clamp_u(d[95:64]));
      phase_trig(clamp_u(d[63:32]), ca, sa);
      phase_trig(clamp_u(d[127:96]), cb, sb);
      v.x = scaled(ra, d[159:128], ca);
      v.y = scaled(ra, d[191:160], sa);
      v.z = scaled(rb, d[223:192], cb);
      velocity_q.push_back(v);
    endfunction

    task report(string what, logic [OW-1:0] got, logic [OW-1:0] want);
      errors++;
      $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    task check_word(logic [119:0] d);
      vel_t got, want;
      got = d;
      if (velocity_q.size() == 0) begin
        report("unexpected word", got.x, '0);
        return;
      end
      want = velocity_q.pop_front();
      if (got.x !== want.x) report("vel_x", got.x, want.x);
      if (got.y !== want.y) report("vel_y", got.y, want.y);
      if (got.z !== want.z) report("vel_z", got.z, want.z);
      matched++;
    endtask
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [223:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [15:0]  cfg_data_i = '0;

  velocity_scoreboard sb = new();
  bit no_idle = 1'b0;
  int words_sent = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  box_muller_gaussian_velocity u_top (.*);

  // receiver: random stalls, results checked before the accepting edge
  always @(posedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= 17);
  end

  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
  end

  task send_word(logic [223:0] d);
    bit hs;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do begin
      @(negedge clk_i);
      hs = s_axis_tvalid && s_axis_tready;
      @(posedge clk_i);
    end while (!hs);
    sb.note_word(d);
    words_sent++;
    if (!no_idle && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task drain();
    s_axis_tvalid <= 1'b0;
    while (sb.velocity_q.size() != 0) @(posedge clk_i);
    repeat (LAT_TOTAL + 8) @(posedge clk_i);
  endtask

  task write_epsilon(logic [15:0] e);
    bit hs;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= e;
    do begin
      @(negedge clk_i);
      hs = cfg_valid_i && cfg_ready_o;
      @(posedge clk_i);
    end while (!hs);
    sb.epsilon = e;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_uniform();
    logic [15:0] e;
    e = sb.epsilon;
    case ($urandom_range(9))
      0: return $urandom_range(e + 2);
      1: return 32'hFFFF_FFFF - $urandom_range(e + 2);
      2: return {2'($urandom_range(3)), 30'h2000_0000} + 32'($urandom_range(4)) - 32'd2;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [223:0] rand_word();
    logic [31:0] sg[3];
    for (int i = 0; i < 3; i++)
      sg[i] = ($urandom_range(3) == 0) ? $urandom_range(32'h0003_0000) : $urandom;
    return {sg[2], sg[1], sg[0], rand_uniform(), rand_uniform(),
            rand_uniform(), rand_uniform()};
  endfunction

  task random_run(int n);
    for (int i = 0; i < n; i++) begin
      no_idle = (i >= n / 3) && (i < n / 3 + 60);
      send_word(rand_word());
      if (i == n / 2) begin
        // hold off until the pipeline is empty
        s_axis_tvalid <= 1'b0;
        while (sb.velocity_q.size() != 0) @(posedge clk_i);
      end
    end
    no_idle = 1'b0;
  endtask

  task directed_run();
    logic [31:0] u[10];
    u = '{32'h0, 32'h1, 32'h2B, 32'h2C, 32'hFFFF_FFFF, 32'hFFFF_FFD5,
          32'h4000_0000, 32'h8000_0000, 32'hC000_0000, 32'h2000_0000};
    for (int i = 0; i < 10; i++)
      send_word({32'hFFFF_FFFF, 32'h0001_0000, 32'h0, u[(i + 3) % 10],
                 u[(i + 5) % 10], u[(i + 7) % 10], u[i]});
    send_word({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'h0, 32'h0, 32'h0, 32'h0});
    send_word({32'h0, 32'h0, 32'h0, 32'h6000_0000, 32'h0,
               32'hE000_0000, 32'hFFFF_FFFF});
    send_word({96'h0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA} |
              {32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 128'h0});
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_run();
    random_run(300);
    drain();
    write_epsilon(16'd0);
    directed_run();
    random_run(250);
    drain();
    write_epsilon(16'd1);
    random_run(250);
    drain();
    write_epsilon(16'hFFFF);
    directed_run();
    random_run(250);
    drain();
    write_epsilon(16'($urandom_range(2, 16'hFFFE)));
    random_run(200);
    drain();
    $display("sent %0d words, %0d results checked, epsilon swept 43/0/1/65535/random",
             words_sent, sb.matched);
    if (sb.errors == 0 && sb.velocity_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/bmgv_pkg.sv
hw/rtl/bmgv_radius.sv
hw/rtl/bmgv_sincos.sv
hw/rtl/bmgv_scale.sv
hw/rtl/box_muller_gaussian_velocity.sv
hw/rtl/bmgv_checker.sv
dv/tb.sv
